@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never hold outside reset
`define MSC_ASSERT_NEVER(lbl, clk_i, rstn_i, expr) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(expr)) \
		else $error("assertion failed: never");

// consequent must hold in the same cycle
`define MSC_ASSERT_IMPLIES(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("assertion failed: implies");

// consequent must hold in the cycle after the antecedent
`define MSC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("assertion failed: next");

`endif

@@ src/msc_pkg.sv @@
// types and constants of the tcp syn mss clamp
`timescale 1ns / 1ps
package msc_pkg;

	localparam logic [15:0] MSS_LIMIT_RESET = 16'd1380;
	localparam logic [15:0] POS_FIRST       = 16'd0;
	localparam logic [15:0] POS_OFFSET      = 16'd12;
	localparam logic [15:0] POS_FLAGS       = 16'd13;
	localparam logic [15:0] POS_MAX         = 16'hFFFF;
	localparam logic [8:0]  OPT_START       = 9'd20;
	localparam logic [5:0]  HDR_MIN         = 6'd20;
	localparam logic [15:0] MSS_OPT_BYTES   = 16'd4;
	localparam logic [7:0]  OPT_KIND_NOP    = 8'd1;
	localparam logic [7:0]  OPT_KIND_MSS    = 8'd2;
	localparam logic [7:0]  OPT_LEN_MIN     = 8'd2;
	localparam logic [7:0]  OPT_LEN_MSS     = 8'd4;
	localparam int          SYN_BIT         = 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
	localparam logic [LVL_W-1:0] LVL_MAX  = LVL_W'(FIFO_DEPTH);
	localparam logic [LVL_W-1:0] LVL_ROOM = LVL_W'(FIFO_DEPTH - 2);

	typedef enum logic [3:0] {
		PH_KIND = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_HIGH = 4'b0100,
		PH_LOW  = 4'b1000
	} msc_phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       rewritten;
	} msc_res_t;

	typedef struct packed {
		logic     v0;
		msc_res_t r0;
		logic     v1;
		msc_res_t r1;
	} msc_push_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             room2;
	} msc_fifo_st_t;

endpackage

@@ src/msc_in_if.sv @@
// request channel carrying segment bytes into the clamp
`timescale 1ns / 1ps
interface msc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [15:0] segment_length;
	logic        last_byte;

	modport source (output valid, output data_byte, output segment_length,
		output last_byte, input ready);
	modport sink (input valid, input data_byte, input segment_length,
		input last_byte, output ready);
endinterface

@@ src/msc_out_if.sv @@
// request channel carrying result bytes out of the clamp
`timescale 1ns / 1ps
interface msc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       rewritten;

	modport source (output valid, output out_byte, output out_last,
		output rewritten, input ready);
	modport sink (input valid, input out_byte, input out_last,
		input rewritten, output ready);
endinterface

@@ src/msc_walk.sv @@
// input register, option walk and mss rewrite, one byte per cycle while the queue has room for two
`timescale 1ns / 1ps
module msc_walk import msc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	msc_in_if.sink       ingress,
	input  msc_fifo_st_t fifo_st,
	output msc_push_t    push
);

	logic        v_s1;
	logic [7:0]  b_s1;
	logic [15:0] len_s1;
	logic        last_s1;

	logic [15:0] limit_q;
	logic [15:0] pos_q;
	logic [5:0]  hdr_q;
	logic [15:0] seglen_q;
	logic        ca_q;
	logic [8:0]  nxt_q;
	msc_phase_t  ph_q;
	logic        km_q;
	logic [7:0]  held_byte_q;
	logic        held_v_q;
	logic        held_rw_q;

	logic [15:0] seglen_d;
	logic [5:0]  hdr_d;
	logic        ca_d;
	logic [8:0]  nxt_d;
	msc_phase_t  ph_d;
	logic        km_d;
	logic [7:0]  b_mod;
	logic [7:0]  held_out;
	logic        held_rw_out;
	logic        cur_rw;
	logic [8:0]  pos9;
	logic        adv;
	logic        accept;

	assign adv           = v_s1 && fifo_st.room2;
	assign ingress.ready = !v_s1 || fifo_st.room2;
	assign accept        = ingress.valid && ingress.ready;
	assign pos9          = pos_q[8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_s1    <= ingress.data_byte;
			len_s1  <= ingress.segment_length;
			last_s1 <= ingress.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= MSS_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_comb begin
		seglen_d    = seglen_q;
		hdr_d       = hdr_q;
		ca_d        = ca_q;
		nxt_d       = nxt_q;
		ph_d        = ph_q;
		km_d        = km_q;
		b_mod       = b_s1;
		held_out    = held_byte_q;
		held_rw_out = held_rw_q;
		cur_rw      = 1'b0;
		if (pos_q == POS_FIRST) begin
			seglen_d = len_s1;
		end
		if (pos_q == POS_OFFSET) begin
			hdr_d = {b_s1[7:4], 2'b00};
		end
		if (pos_q == POS_FLAGS) begin
			ca_d  = b_s1[SYN_BIT] && (hdr_q > HDR_MIN) && ({10'd0, hdr_q} <= seglen_q);
			nxt_d = OPT_START;
			ph_d  = PH_KIND;
			km_d  = 1'b0;
		end
		if (ca_q && (pos_q >= {7'd0, OPT_START})) begin
			unique case (ph_q)
				PH_KIND: begin
					if (nxt_q >= {3'd0, hdr_q}) begin
						ca_d = 1'b0;
					end else if (pos_q == {7'd0, nxt_q}) begin
						if (b_s1 <= OPT_KIND_NOP) begin
							nxt_d = pos9 + 9'd1;
						end else begin
							km_d = (b_s1 == OPT_KIND_MSS) &&
								(({10'd0, hdr_q} - pos_q) >= MSS_OPT_BYTES);
							ph_d = PH_LEN;
						end
					end
				end
				PH_LEN: begin
					if (km_q && (b_s1 == OPT_LEN_MSS)) begin
						ph_d = PH_HIGH;
					end else begin
						if (b_s1 < OPT_LEN_MIN) begin
							nxt_d = pos9 + 9'd1;
						end else begin
							nxt_d = pos9 + {1'b0, b_s1} - 9'd1;
						end
						ph_d = PH_KIND;
					end
				end
				PH_HIGH: begin
					ph_d = PH_LOW;
				end
				PH_LOW: begin
					if (held_v_q && ({held_byte_q, b_s1} > limit_q)) begin
						held_out    = limit_q[15:8];
						held_rw_out = 1'b1;
						b_mod       = limit_q[7:0];
						cur_rw      = 1'b1;
					end
					ca_d = 1'b0;
				end
				default: begin
					ph_d = PH_KIND;
				end
			endcase
		end
	end

	always_comb begin
		push = '0;
		if (adv) begin
			if (held_v_q) begin
				push.v0 = 1'b1;
				push.r0 = '{out_byte: held_out, out_last: 1'b0, rewritten: held_rw_out};
				if (last_s1) begin
					push.v1 = 1'b1;
					push.r1 = '{out_byte: b_mod, out_last: 1'b1, rewritten: cur_rw};
				end
			end else if (last_s1) begin
				push.v0 = 1'b1;
				push.r0 = '{out_byte: b_mod, out_last: 1'b1, rewritten: cur_rw};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_q       <= '0;
			seglen_q    <= '0;
			ca_q        <= 1'b0;
			nxt_q       <= OPT_START;
			ph_q        <= PH_KIND;
			km_q        <= 1'b0;
			held_byte_q <= '0;
			held_v_q    <= 1'b0;
			held_rw_q   <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q       <= '0;
				hdr_q       <= '0;
				seglen_q    <= '0;
				ca_q        <= 1'b0;
				nxt_q       <= OPT_START;
				ph_q        <= PH_KIND;
				km_q        <= 1'b0;
				held_byte_q <= '0;
				held_v_q    <= 1'b0;
				held_rw_q   <= 1'b0;
			end else begin
				hdr_q       <= hdr_d;
				seglen_q    <= seglen_d;
				ca_q        <= ca_d;
				nxt_q       <= nxt_d;
				ph_q        <= ph_d;
				km_q        <= km_d;
				held_byte_q <= b_mod;
				held_v_q    <= 1'b1;
				held_rw_q   <= cur_rw;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 16'd1;
				end
			end
		end
	end

endmodule

@@ src/msc_out_fifo.sv @@
// small result queue taking up to two bytes per cycle
`timescale 1ns / 1ps
module msc_out_fifo import msc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  msc_push_t    push,
	output msc_fifo_st_t fifo_st,
	msc_out_if.source    egress
);

	msc_res_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [LVL_W-1:0]     lvl_q;
	logic                 pop;
	logic [1:0]           n_push;
	msc_res_t             head;

	assign n_push = {1'b0, push.v0} + {1'b0, push.v1};
	assign pop    = (lvl_q != '0) && egress.ready;
	assign head   = mem_q[rd_q];

	assign egress.valid     = lvl_q != '0;
	assign egress.out_byte  = head.out_byte;
	assign egress.out_last  = head.out_last;
	assign egress.rewritten = head.rewritten;

	assign fifo_st.level = lvl_q;
	assign fifo_st.room2 = lvl_q <= LVL_ROOM;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_q + FIFO_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			lvl_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_AW'(n_push);
			lvl_q <= lvl_q + LVL_W'(n_push) - LVL_W'(pop);
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
		end
	end

endmodule

@@ src/tcp_syn_mss_clamp.sv @@
// top level of the tcp syn mss clamp
//
// ingress takes one tcp segment byte per request with the segment length
// (sampled on the first byte) and a last-byte flag; egress returns the same
// bytes, with an oversized mss option value replaced by the limit on syn
// segments. cfg_we/cfg_wdata load the mss limit, which must be written only
// while idle; the block does not enforce this. one byte is accepted per
// cycle, sustained, while egress is ready. each byte is registered and the
// option walk works on it combinationally, pushing results into a
// four-entry queue feeding egress. a byte is held until the next byte of
// its segment advances, then pushed; the last byte pushes the held byte and
// itself into the queue together, in that order. the queue drains one byte
// per cycle while egress is ready and sets the rate. when egress stalls the
// queue fills and ingress ready drops once fewer than two entries are free
// and a byte waits in the input register; nothing is lost. reset empties
// the queue, clears the walk state and restores the limit to 1380.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcp_syn_mss_clamp import msc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	msc_in_if.sink      ingress,
	msc_out_if.source   egress
);

	msc_push_t    push;
	msc_fifo_st_t fifo_st;

	msc_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ingress   (ingress),
		.fifo_st   (fifo_st),
		.push      (push)
	);

	msc_out_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.fifo_st (fifo_st),
		.egress  (egress)
	);

	`MSC_ASSERT_IMPLIES(a_pair_order, clk, arst_n, push.v1,
		push.v0 && !push.r0.out_last && push.r1.out_last)
	`MSC_ASSERT_NEVER(a_level_max, clk, arst_n, fifo_st.level > LVL_MAX)
	`MSC_ASSERT_NEXT(a_push_shows, clk, arst_n, push.v0, egress.valid)
	`MSC_ASSERT_IMPLIES(a_push_room, clk, arst_n, push.v0, fifo_st.room2)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// testbench of the tcp syn mss clamp: random segment bytes checked against a byte predictor
module tb;
	import msc_pkg::*;

	localparam int RUN_LIMIT    = 6000000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] segment_length;
		logic        last_byte;
	} seg_byte_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	msc_in_if  ing();
	msc_out_if egr();

	tcp_syn_mss_clamp dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.ingress(ing),
		.egress(egr)
	);

	seg_byte_t  tx_q[$];
	msc_res_t   clamped_q[$];
	logic [7:0] seg_build[$];
	int         err_count = 0;
	int         cyc_count = 0;

	// predictor state
	logic [15:0] mss_cap;
	logic [15:0] seg_pos;
	logic [5:0]  hdr_len;
	logic [15:0] seg_len;
	logic        walk_on;
	logic [15:0] opt_next;
	msc_phase_t  walk_ph;
	logic        opt_mss;
	logic [7:0]  hold_byte;
	logic        hold_v;
	logic        hold_rw;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("tb: %s mismatch at %0t ns: got %0h, expected %0h", field, $realtime, got, want);
		err_count++;
	endtask

	task automatic seg_restart;
		seg_pos  = POS_FIRST;
		hdr_len  = '0;
		seg_len  = '0;
		walk_on  = 1'b0;
		opt_next = 16'(OPT_START);
		walk_ph  = PH_KIND;
		opt_mss  = 1'b0;
	endtask

	task automatic clamp_step(input seg_byte_t it);
		logic [7:0]  b;
		logic [15:0] p;
		logic [15:0] mss;
		logic        cur_rw;
		msc_res_t    r;
		b = it.data_byte;
		p = seg_pos;
		cur_rw = 1'b0;
		if (p == POS_FIRST)
			seg_len = it.segment_length;
		if (p == POS_OFFSET)
			hdr_len = {b[7:4], 2'b00};
		if (p == POS_FLAGS) begin
			walk_on = b[SYN_BIT] && (hdr_len > HDR_MIN) && ({10'd0, hdr_len} <= seg_len);
			opt_next = 16'(OPT_START);
			walk_ph = PH_KIND;
			opt_mss = 1'b0;
		end
		if (walk_on && p >= 16'(OPT_START)) begin
			case (walk_ph)
				PH_KIND: begin
					if (opt_next >= {10'd0, hdr_len}) begin
						walk_on = 1'b0;
					end else if (p == opt_next) begin
						if (b < OPT_LEN_MIN) begin
							opt_next = p + 16'd1;
						end else begin
							opt_mss = (b == OPT_KIND_MSS) &&
								(({10'd0, hdr_len} - p) >= MSS_OPT_BYTES);
							walk_ph = PH_LEN;
						end
					end
				end
				PH_LEN: begin
					if (opt_mss && b == OPT_LEN_MSS) begin
						walk_ph = PH_HIGH;
					end else begin
						if (b < OPT_LEN_MIN)
							opt_next = p + 16'd1;
						else
							opt_next = p - 16'd1 + {8'd0, b};
						walk_ph = PH_KIND;
					end
				end
				PH_HIGH: walk_ph = PH_LOW;
				PH_LOW: begin
					mss = {hold_byte, b};
					if (hold_v && mss > mss_cap) begin
						hold_byte = mss_cap[15:8];
						hold_rw = 1'b1;
						b = mss_cap[7:0];
						cur_rw = 1'b1;
					end
					walk_on = 1'b0;
				end
				default: ;
			endcase
		end
		if (hold_v) begin
			r.out_byte = hold_byte;
			r.out_last = 1'b0;
			r.rewritten = hold_rw;
			clamped_q.push_back(r);
		end
		if (it.last_byte) begin
			r.out_byte = b;
			r.out_last = 1'b1;
			r.rewritten = cur_rw;
			clamped_q.push_back(r);
			hold_v = 1'b0;
			hold_rw = 1'b0;
			hold_byte = '0;
			seg_restart();
		end else begin
			hold_byte = b;
			hold_v = 1'b1;
			hold_rw = cur_rw;
			if (seg_pos != POS_MAX)
				seg_pos = seg_pos + 16'd1;
		end
	endtask

	task automatic push_segment(input logic [15:0] seglen);
		seg_byte_t it;
		for (int i = 0; i < seg_build.size(); i++) begin
			it.data_byte = seg_build[i];
			it.segment_length = (i == 0) ? seglen : 16'($urandom);
			it.last_byte = (i == seg_build.size() - 1);
			tx_q.push_back(it);
		end
		seg_build.delete();
	endtask

	task automatic wait_drained;
		do @(posedge clk); while (tx_q.size() != 0 || ing.valid || clamped_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		seg_byte_t it;
		if (!arst_n) begin
			ing.valid <= 1'b0;
			ing.data_byte <= '0;
			ing.segment_length <= '0;
			ing.last_byte <= 1'b0;
		end else begin
			if (ing.valid && ing.ready) begin
				it.data_byte = ing.data_byte;
				it.segment_length = ing.segment_length;
				it.last_byte = ing.last_byte;
				clamp_step(it);
			end
			if (!ing.valid || ing.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					ing.valid <= 1'b0;
				end else if (tx_q.size() != 0) begin
					it = tx_q.pop_front();
					ing.valid <= 1'b1;
					ing.data_byte <= it.data_byte;
					ing.segment_length <= it.segment_length;
					ing.last_byte <= it.last_byte;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					ing.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: receiver stalls follow a randomly picked mode, one of four
	int unsigned rx_cyc = 0;
	int unsigned rx_mode = 0;

	always @(posedge clk or negedge arst_n) begin
		msc_res_t want;
		if (!arst_n) begin
			egr.ready <= 1'b0;
		end else begin
			if (egr.valid && egr.ready) begin
				if (clamped_q.size() == 0) begin
					report_mismatch("unexpected byte", egr.out_byte, -1);
				end else begin
					want = clamped_q.pop_front();
					if (egr.out_byte !== want.out_byte)
						report_mismatch("out_byte", egr.out_byte, want.out_byte);
					if (egr.out_last !== want.out_last)
						report_mismatch("out_last", egr.out_last, want.out_last);
					if (egr.rewritten !== want.rewritten)
						report_mismatch("rewritten", egr.rewritten, want.rewritten);
				end
			end
			rx_cyc++;
			if (rx_cyc[4:0] == 5'd0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: egr.ready <= 1'b1;
				1: egr.ready <= (rx_cyc[1:0] != 2'd0);
				2: egr.ready <= ($urandom_range(0, 9) < 7);
				default: egr.ready <= (rx_cyc[4:3] != 2'd0);
			endcase
		end
	end

	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count >= RUN_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		logic [15:0] phase_cap[6];
		logic [15:0] seglen;
		logic [15:0] mssv;
		logic [7:0]  flags;
		int          added;
		int          doff;
		int          hdr;
		int          pick;
		int          olen;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		ing.valid = 1'b0;
		ing.data_byte = '0;
		ing.segment_length = '0;
		ing.last_byte = 1'b0;
		egr.ready = 1'b0;
		mss_cap = MSS_LIMIT_RESET;
		seg_restart();
		hold_byte = '0;
		hold_v = 1'b0;
		hold_rw = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// syn with an mss of all ones ending on its low byte, then a one-byte segment
		for (int i = 0; i < 12; i++)
			seg_build.push_back(i[0] ? 8'hFF : 8'h00);
		seg_build.push_back(8'h60);
		seg_build.push_back(8'h02);
		repeat (6) seg_build.push_back(8'hFF);
		seg_build.push_back(OPT_KIND_MSS);
		seg_build.push_back(OPT_LEN_MSS);
		seg_build.push_back(8'hFF);
		seg_build.push_back(8'hFF);
		push_segment(16'd24);
		seg_build.push_back(8'hFF);
		push_segment(16'hFFFF);

		phase_cap[0] = MSS_LIMIT_RESET;
		phase_cap[1] = 16'h0000;
		phase_cap[2] = 16'hFFFF;
		phase_cap[3] = 16'($urandom);
		phase_cap[4] = 16'd536;
		phase_cap[5] = 16'd1460;

		for (int ph = 0; ph < 6; ph++) begin
			if (ph != 0) begin
				wait_drained();
				cfg_we <= 1'b1;
				cfg_wdata <= phase_cap[ph];
				mss_cap = phase_cap[ph];
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			added = 0;
			while (added < 80) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise
					repeat ($urandom_range(1, 30)) seg_build.push_back(8'($urandom));
					added += seg_build.size();
					push_segment(16'($urandom));
				end else begin
					doff = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 15);
					hdr = doff * 4;
					repeat (12) seg_build.push_back(8'($urandom));
					seg_build.push_back({doff[3:0], 4'($urandom)});
					flags = 8'($urandom);
					if ($urandom_range(0, 4) != 0)
						flags[SYN_BIT] = 1'b1;
					seg_build.push_back(flags);
					repeat (6) seg_build.push_back(8'($urandom));
					while (seg_build.size() < hdr) begin
						pick = $urandom_range(0, 9);
						case (pick)
							0: seg_build.push_back(8'h00);
							1, 2: seg_build.push_back(OPT_KIND_NOP);
							3, 4, 5: begin
								case ($urandom_range(0, 5))
									0: mssv = mss_cap;
									1: mssv = mss_cap + 16'd1;
									2: mssv = mss_cap - 16'd1;
									3: mssv = 16'hFFFF;
									4: mssv = 16'h0000;
									default: mssv = 16'($urandom);
								endcase
								seg_build.push_back(OPT_KIND_MSS);
								seg_build.push_back(OPT_LEN_MSS);
								seg_build.push_back(mssv[15:8]);
								seg_build.push_back(mssv[7:0]);
							end
							6: begin
								seg_build.push_back(OPT_KIND_MSS);
								seg_build.push_back(8'($urandom_range(0, 6)));
							end
							7: begin
								olen = $urandom_range(2, 10);
								seg_build.push_back(8'($urandom_range(3, 255)));
								seg_build.push_back(8'(olen));
								repeat (olen - 2) seg_build.push_back(8'($urandom));
							end
							8: begin
								// length byte of zero or one
								seg_build.push_back(8'($urandom_range(3, 30)));
								seg_build.push_back(8'($urandom_range(0, 1)));
							end
							default: seg_build.push_back(8'($urandom));
						endcase
					end
					if (hdr >= 20)
						while (seg_build.size() > hdr) void'(seg_build.pop_back());
					repeat ($urandom_range(0, 12)) seg_build.push_back(8'($urandom));
					case ($urandom_range(0, 7))
						0: seglen = 16'($urandom);
						1: seglen = 16'(hdr - 1);
						default: seglen = 16'(seg_build.size());
					endcase
					// segment ends early
					if ($urandom_range(0, 9) == 0)
						while (seg_build.size() > 1 && $urandom_range(0, 3) != 0)
							void'(seg_build.pop_back());
					added += seg_build.size();
					push_segment(seglen);
				end
			end
		end

		wait_drained();
		if (err_count == 0 && clamped_q.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
